/* rtl/frr_pkg.sv */
// Package for the Fresnel reflectance pipeline: request and result types,
// pipeline widths and the fixed latency. No dependencies.
package frr_pkg;

    typedef struct packed {
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [14:0]        refr_index;
    } request_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } result_t;

    localparam int FRR_NN_W    = 30;
    localparam int FRR_ST2_QW  = 31;
    localparam int FRR_CT_W    = 29;
    localparam int FRR_CDEN_W  = 45;
    localparam int FRR_COEF_QW = 17;

    localparam logic [15:0] FRR_ONE_Q15 = 16'h8000;

    localparam int FRR_LATENCY = 5 + (FRR_ST2_QW + 1) + (FRR_CT_W + 1) + 2
                               + (FRR_COEF_QW + 1) + 2;

endpackage

/* rtl/fresnel_reflectance_top.sv */
// Top level of the dielectric Fresnel reflectance pipeline.
// Depends on frr_pkg, frr_div and frr_sqrt.
//
// Channel   Ports                  Handshake
// request   start, busy, request   taken when start is high and busy is low
// result    done, result           valid for the one cycle that done is high
//
// A new request can be taken in every cycle; busy stays low.
// The sine divider (32 stages), the square root (30 stages) and the coefficient
// dividers (18 stages) set most of the latency from a request to its result.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so the pipeline never holds.
module fresnel_reflectance_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  frr_pkg::request_t request,
    output logic              done,
    output frr_pkg::result_t  result
);
    import frr_pkg::*;

    localparam logic [33:0] ONE_Q28   = 34'd1 << 28;
    localparam logic [56:0] ONE_Q56   = 57'd1 << 56;
    localparam logic [60:0] ONE_Q56_W = 61'd1 << 56;
    localparam logic [30:0] ONE_Q30   = 31'd1 << 30;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Stage 1: products.
    logic               vld1_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] px_next, py_next, pz_next;
    logic [14:0]        n1_reg, n1_next;

    assign px_next = request.incident_x * request.normal_x;
    assign py_next = request.incident_y * request.normal_y;
    assign pz_next = request.incident_z * request.normal_z;
    assign n1_next = (request.refr_index == 15'd0) ? 15'd1 : request.refr_index;

    // Stage 2: clamped dot and cosine.
    logic               vld2_reg;
    logic signed [33:0] dot_sum, dot_clamp;
    logic [33:0]        dot_abs;
    logic [28:0]        ci2_reg;
    logic               in2_reg;
    logic [14:0]        n2_reg;

    assign dot_sum = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
    always_comb
    begin
        if (dot_sum > $signed(ONE_Q28))
        begin
            dot_clamp = $signed(ONE_Q28);
        end
        else if (dot_sum < -$signed(ONE_Q28))
        begin
            dot_clamp = -$signed(ONE_Q28);
        end
        else
        begin
            dot_clamp = dot_sum;
        end
    end
    assign dot_abs = (dot_clamp < 0) ? 34'(-dot_clamp) : 34'(dot_clamp);

    // Stage 3: squares.
    logic        vld3_reg;
    logic [57:0] cc3_reg;
    logic [29:0] nn3_reg;
    logic [28:0] ci3_reg;
    logic        in3_reg;
    logic [14:0] n3_reg;

    // Stage 4: sine squared of the incident angle.
    logic        vld4_reg;
    logic [56:0] s2_diff;
    logic [30:0] s2_4_reg;
    logic [29:0] nn4_reg;
    logic [28:0] ci4_reg;
    logic        in4_reg;
    logic [14:0] n4_reg;

    assign s2_diff = ONE_Q56 - cc3_reg[56:0];

    // Stage 5: scaled sine and the outside total reflection test.
    logic        vld5_reg;
    logic [60:0] prod5_reg;
    logic        tiro5_reg;
    logic [30:0] s2_5_reg;
    logic [29:0] nn5_reg;
    logic [28:0] ci5_reg;
    logic        in5_reg;
    logic [14:0] n5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        n1_reg    <= n1_next;

        ci2_reg   <= dot_abs[28:0];
        in2_reg   <= dot_clamp > 0;
        n2_reg    <= n1_reg;

        cc3_reg   <= 58'(ci2_reg) * 58'(ci2_reg);
        nn3_reg   <= 30'(n2_reg) * 30'(n2_reg);
        ci3_reg   <= ci2_reg;
        in3_reg   <= in2_reg;
        n3_reg    <= n2_reg;

        s2_4_reg  <= s2_diff[56:26];
        nn4_reg   <= nn3_reg;
        ci4_reg   <= ci3_reg;
        in4_reg   <= in3_reg;
        n4_reg    <= n3_reg;

        prod5_reg <= 61'(s2_4_reg) * 61'(nn4_reg);
        tiro5_reg <= {3'b000, s2_4_reg} > {nn4_reg, 4'b0000};
        s2_5_reg  <= s2_4_reg;
        nn5_reg   <= nn4_reg;
        ci5_reg   <= ci4_reg;
        in5_reg   <= in4_reg;
        n5_reg    <= n4_reg;
    end

    // Sine squared of the transmitted angle.
    localparam int D1_SIDE_W = 1 + 1 + 31 + 29 + 15;

    logic                 tir5;
    logic [34:0]          st2i_wide;
    logic [30:0]          st2i;
    logic [D1_SIDE_W-1:0] d1_side_in, d1_side_out;
    logic                 d1_valid;
    logic [FRR_ST2_QW-1:0] d1_quo;

    assign tir5      = in5_reg ? (prod5_reg > ONE_Q56_W) : tiro5_reg;
    assign st2i_wide = prod5_reg[60:26];
    assign st2i      = (st2i_wide > 35'(ONE_Q30)) ? ONE_Q30 : st2i_wide[30:0];
    assign d1_side_in = {in5_reg, tir5, st2i, ci5_reg, n5_reg};

    frr_div #(
        .DEN_W  (FRR_NN_W),
        .Q_W    (FRR_ST2_QW),
        .SIDE_W (D1_SIDE_W)
    ) u_div_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld5_reg),
        .hi        ({3'b000, s2_5_reg[30:4]}),
        .lo        ({s2_5_reg[3:0], 26'd0}),
        .den       (nn5_reg),
        .side      (d1_side_in),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side_out)
    );

    logic        d1_inside, d1_tir;
    logic [30:0] d1_st2i, d1_quoc, st2;
    logic [28:0] d1_ci;
    logic [14:0] d1_n;
    logic [30:0] cos2;

    assign {d1_inside, d1_tir, d1_st2i, d1_ci, d1_n} = d1_side_out;
    assign d1_quoc = (d1_quo > ONE_Q30) ? ONE_Q30 : d1_quo;
    assign st2     = d1_inside ? d1_st2i : d1_quoc;
    assign cos2    = ONE_Q30 - st2;

    // Cosine of the transmitted angle.
    localparam int SQ_SIDE_W = 1 + 29 + 15;

    logic                 sq_valid;
    logic [FRR_CT_W-1:0]  ct;
    logic [SQ_SIDE_W-1:0] sq_side_out;
    logic                 sq_tir;
    logic [28:0]          sq_ci;
    logic [14:0]          sq_n;

    frr_sqrt #(
        .RES_W  (FRR_CT_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .rad       ({1'b0, cos2, 26'd0}),
        .side      ({d1_tir, d1_ci, d1_n}),
        .out_valid (sq_valid),
        .root      (ct),
        .side_out  (sq_side_out)
    );

    assign {sq_tir, sq_ci, sq_n} = sq_side_out;

    // Index products, then numerators and denominators.
    logic        vldm_reg, vldn_reg;
    logic [43:0] w_reg, v_reg;
    logic [28:0] cim_reg, ctm_reg;
    logic        tirm_reg, tirn_reg;
    logic [43:0] u_val, z_val;
    logic [44:0] dena_reg, denb_reg;
    logic [43:0] numa_reg, numb_reg;

    assign u_val = {2'b00, cim_reg, 13'd0};
    assign z_val = {2'b00, ctm_reg, 13'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldm_reg <= 1'b0;
            vldn_reg <= 1'b0;
        end
        else
        begin
            vldm_reg <= sq_valid;
            vldn_reg <= vldm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= 44'(sq_n) * 44'(sq_ci);
        v_reg    <= 44'(sq_n) * 44'(ct);
        cim_reg  <= sq_ci;
        ctm_reg  <= ct;
        tirm_reg <= sq_tir;

        dena_reg <= {1'b0, u_val} + {1'b0, v_reg};
        numa_reg <= (u_val >= v_reg) ? (u_val - v_reg) : (v_reg - u_val);
        denb_reg <= {1'b0, w_reg} + {1'b0, z_val};
        numb_reg <= (w_reg >= z_val) ? (w_reg - z_val) : (z_val - w_reg);
        tirn_reg <= tirm_reg;
    end

    // Coefficient magnitudes.
    logic                   da_valid, db_valid;
    logic [FRR_COEF_QW-1:0] da_quo, db_quo;
    logic [1:0]             da_side;
    logic                   db_side;

    frr_div #(
        .DEN_W  (FRR_CDEN_W),
        .Q_W    (FRR_COEF_QW),
        .SIDE_W (2)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vldn_reg),
        .hi        ({1'b0, numa_reg}),
        .lo        ('0),
        .den       (dena_reg),
        .side      ({tirn_reg, dena_reg == '0}),
        .out_valid (da_valid),
        .quo       (da_quo),
        .side_out  (da_side)
    );

    frr_div #(
        .DEN_W  (FRR_CDEN_W),
        .Q_W    (FRR_COEF_QW),
        .SIDE_W (1)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vldn_reg),
        .hi        ({1'b0, numb_reg}),
        .lo        ('0),
        .den       (denb_reg),
        .side      (denb_reg == '0),
        .out_valid (db_valid),
        .quo       (db_quo),
        .side_out  (db_side)
    );

    // Squares, then the rounded mean.
    logic        vlds_reg;
    logic [33:0] sqa_reg, sqb_reg;
    logic        tirs_reg;
    logic [16:0] coef_a, coef_b;
    logic [34:0] sum_rnd;
    logic [16:0] refl_wide;
    logic [15:0] refl;
    logic        done_reg;
    result_t     result_reg, result_next;

    assign coef_a = da_side[0] ? 17'h10000 : da_quo;
    assign coef_b = db_side    ? 17'h10000 : db_quo;

    assign sum_rnd   = {1'b0, sqa_reg} + {1'b0, sqb_reg} + (35'd1 << 17);
    assign refl_wide = sum_rnd[34:18];
    assign refl      = (refl_wide > {1'b0, FRR_ONE_Q15}) ? FRR_ONE_Q15 : refl_wide[15:0];

    always_comb
    begin
        result_next.reflectance    = tirs_reg ? FRR_ONE_Q15 : refl;
        result_next.total_internal = tirs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlds_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vlds_reg <= da_valid & db_valid;
            done_reg <= vlds_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqa_reg    <= 34'(coef_a) * 34'(coef_a);
        sqb_reg    <= 34'(coef_b) * 34'(coef_b);
        tirs_reg   <= da_side[1];
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/frr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Depends on nothing.
module frr_div #(
    parameter int DEN_W  = 30,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  hi,
    input  logic [Q_W-2:0]    lo,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [0:Q_W];
    logic [DEN_W-1:0]  rem_reg  [0:Q_W];
    logic [Q_W-2:0]    lo_reg   [0:Q_W];
    logic [DEN_W-1:0]  den_reg  [0:Q_W];
    logic [Q_W-1:0]    quo_reg  [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= hi;
        lo_reg[0]   <= lo;
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        side_reg[0] <= side;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   rem_next;
        logic [Q_W-2:0]   lo_next;

        if (k == 0)
        begin : g_first
            assign trial   = {1'b0, rem_reg[k]};
            assign lo_next = lo_reg[k];
        end
        else
        begin : g_rest
            assign trial   = {rem_reg[k], lo_reg[k][Q_W-2]};
            assign lo_next = lo_reg[k] << 1;
        end

        assign ge       = trial >= {1'b0, den_reg[k]};
        assign rem_next = ge ? (trial - {1'b0, den_reg[k]}) : trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next[DEN_W-1:0];
            lo_reg[k+1]   <= lo_next;
            den_reg[k+1]  <= den_reg[k];
            quo_reg[k+1]  <= {quo_reg[k][Q_W-2:0], ge};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quo       = quo_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

/* rtl/frr_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside. Depends on nothing.
module frr_sqrt #(
    parameter int RES_W  = 29,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2*RES_W-1:0] rad,
    input  logic [SIDE_W-1:0]  side,
    output logic               out_valid,
    output logic [RES_W-1:0]   root,
    output logic [SIDE_W-1:0]  side_out
);

    logic               vld_reg  [0:RES_W];
    logic [RES_W+1:0]   rem_reg  [0:RES_W];
    logic [RES_W-1:0]   root_reg [0:RES_W];
    logic [2*RES_W-1:0] rad_reg  [0:RES_W];
    logic [SIDE_W-1:0]  side_reg [0:RES_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        rad_reg[0]  <= rad;
        side_reg[0] <= side;
    end

    for (genvar k = 0; k < RES_W; k++)
    begin : g_step
        logic [RES_W+3:0] cur;
        logic [RES_W+3:0] trial;
        logic             ge;
        logic [RES_W+3:0] rem_next;

        assign cur      = {rem_reg[k], rad_reg[k][2*RES_W-1:2*RES_W-2]};
        assign trial    = {2'b00, root_reg[k], 2'b01};
        assign ge       = cur >= trial;
        assign rem_next = ge ? (cur - trial) : cur;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next[RES_W+1:0];
            root_reg[k+1] <= {root_reg[k][RES_W-2:0], ge};
            rad_reg[k+1]  <= rad_reg[k] << 2;
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[RES_W];
    assign root      = root_reg[RES_W];
    assign side_out  = side_reg[RES_W];

endmodule

/* rtl/frr_checker.sv */
// Port-level checks for the Fresnel reflectance top level, bound to it below.
// Depends on frr_pkg and fresnel_reflectance_top.
module frr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input frr_pkg::request_t request,
    input logic              done,
    input frr_pkg::result_t  result
);
    import frr_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised by a pipeline that never holds");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, FRR_LATENCY))
        else $error("result without a request at the fixed latency");

    a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.total_internal |-> result.reflectance == FRR_ONE_Q15)
        else $error("total internal reflection without full reflectance");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.reflectance <= FRR_ONE_Q15)
        else $error("reflectance above one");

endmodule

bind fresnel_reflectance_top frr_checker u_frr_checker (.*);
